// ===== rtl/arvt_pkg.sv =====
// Shared types, constants and the arctangent table for the axis rotation
// vertex transform. No dependencies; every other file but arvt_tb_pkg uses it by scoped name.
package arvt_pkg;

  localparam int DEFAULT_COORD_WIDTH   = 16;
  localparam int DEFAULT_CORDIC_STAGES = 16;

  // CORDIC datapath widths: x/y in Q1.30 with headroom, angle in binary turns
  localparam int XY_W = 33;
  localparam int Z_W  = 32;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sh0_26DD_3B6A;

  // Angle bookkeeping: theta = round(q * 2^32 / 1440) kept as quotient + remainder
  localparam int ANGLE_W = 11;
  localparam logic [ANGLE_W-1:0] QUARTERS_FULL_TURN = 11'd1440;
  localparam logic [ANGLE_W-1:0] REM_INIT           = 11'd720;
  localparam logic [ANGLE_W-1:0] REM_STEP           = 11'd256;
  localparam logic [Z_W-1:0]     THETA_STEP         = 32'd2982616;

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef struct packed {
    axis_t axis;
    logic  neg;
  } ctrl_t;

  function automatic logic [Z_W-1:0] atan_turn(input int idx);
    logic [Z_W-1:0] v;
    case (idx)
      0:       v = 32'h2000_0000;
      1:       v = 32'h12E4_051E;
      2:       v = 32'h09FB_385B;
      3:       v = 32'h0511_11D4;
      4:       v = 32'h028B_0D43;
      5:       v = 32'h0145_D7E1;
      6:       v = 32'h00A2_F61E;
      7:       v = 32'h0051_7C55;
      8:       v = 32'h0028_BE53;
      9:       v = 32'h0014_5F2F;
      10:      v = 32'h000A_2F98;
      11:      v = 32'h0005_17CC;
      12:      v = 32'h0002_8BE6;
      13:      v = 32'h0001_45F3;
      14:      v = 32'h0000_A2FA;
      15:      v = 32'h0000_517D;
      16:      v = 32'h0000_28BE;
      17:      v = 32'h0000_145F;
      18:      v = 32'h0000_0A30;
      19:      v = 32'h0000_0518;
      20:      v = 32'h0000_028C;
      21:      v = 32'h0000_0146;
      22:      v = 32'h0000_00A3;
      23:      v = 32'h0000_0051;
      24:      v = 32'h0000_0029;
      25:      v = 32'h0000_0014;
      26:      v = 32'h0000_000A;
      27:      v = 32'h0000_0005;
      28:      v = 32'h0000_0003;
      29:      v = 32'h0000_0001;
      30:      v = 32'h0000_0001;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/arvt_cordic_cell.sv =====
// One CORDIC rotation cell: a fixed shift and arctangent step, registered.
// Depends on arvt_pkg. Cells chain through a valid/ready handshake.
module arvt_cordic_cell #(
  parameter int COORD_WIDTH = arvt_pkg::DEFAULT_COORD_WIDTH,
  parameter int STAGE       = 0
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  logic signed [arvt_pkg::XY_W-1:0]   up_x,
  input  logic signed [arvt_pkg::XY_W-1:0]   up_y,
  input  logic signed [arvt_pkg::Z_W-1:0]    up_z,
  input  logic        [3*COORD_WIDTH-1:0]    up_coords,
  input  arvt_pkg::ctrl_t                    up_ctrl,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output logic signed [arvt_pkg::XY_W-1:0]   dn_x,
  output logic signed [arvt_pkg::XY_W-1:0]   dn_y,
  output logic signed [arvt_pkg::Z_W-1:0]    dn_z,
  output logic        [3*COORD_WIDTH-1:0]    dn_coords,
  output arvt_pkg::ctrl_t                    dn_ctrl
);

  localparam logic signed [arvt_pkg::Z_W-1:0] ATAN = $signed(arvt_pkg::atan_turn(STAGE));

  logic                               vld_r;
  logic signed [arvt_pkg::XY_W-1:0]   x_r, x_nxt;
  logic signed [arvt_pkg::XY_W-1:0]   y_r, y_nxt;
  logic signed [arvt_pkg::Z_W-1:0]    z_r, z_nxt;
  logic        [3*COORD_WIDTH-1:0]    coords_r;
  arvt_pkg::ctrl_t                    ctrl_r;

  // rotate toward zero residual angle
  always_comb begin
    if (!up_z[arvt_pkg::Z_W-1]) begin
      x_nxt = up_x - (up_y >>> STAGE);
      y_nxt = up_y + (up_x >>> STAGE);
      z_nxt = up_z - ATAN;
    end else begin
      x_nxt = up_x + (up_y >>> STAGE);
      y_nxt = up_y - (up_x >>> STAGE);
      z_nxt = up_z + ATAN;
    end
  end

  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      z_r      <= z_nxt;
      coords_r <= up_coords;
      ctrl_r   <= up_ctrl;
    end
  end

  assign dn_valid  = vld_r;
  assign dn_x      = x_r;
  assign dn_y      = y_r;
  assign dn_z      = z_r;
  assign dn_coords = coords_r;
  assign dn_ctrl   = ctrl_r;

endmodule

// ===== rtl/arvt_combine.sv =====
// Rotation combine: coordinate times cosine/sine, sum, round and saturate.
// Depends on arvt_pkg. Three registered stages; the last one is the output.
module arvt_combine #(
  parameter int COORD_WIDTH = arvt_pkg::DEFAULT_COORD_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               up_valid,
  output logic                               up_ready,
  input  logic signed [arvt_pkg::XY_W-1:0]   up_cos,
  input  logic signed [arvt_pkg::XY_W-1:0]   up_sin,
  input  logic        [3*COORD_WIDTH-1:0]    up_coords,
  input  arvt_pkg::ctrl_t                    up_ctrl,
  output logic                               dn_valid,
  input  logic                               dn_ready,
  output logic signed [COORD_WIDTH-1:0]      dn_x,
  output logic signed [COORD_WIDTH-1:0]      dn_y,
  output logic signed [COORD_WIDTH-1:0]      dn_z
);

  localparam int PW = COORD_WIDTH + arvt_pkg::XY_W;
  localparam int SW = PW + 2;
  localparam int RW = SW - 30;
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(64'sd1 << 29);
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (COORD_WIDTH - 1)) - 1);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-(64'sd1 <<< (COORD_WIDTH - 1)));

  logic signed [COORD_WIDTH-1:0] cx, cy, cz;
  logic signed [COORD_WIDTH-1:0] op_a, op_b;

  // stage 1: products
  logic                   v1_r, rdy1;
  logic signed [PW-1:0]   pac_r, pbs_r, pas_r, pbc_r;
  logic [3*COORD_WIDTH-1:0] coords1_r;
  arvt_pkg::ctrl_t        ctrl1_r;

  // stage 2: sums
  logic                   v2_r, rdy2;
  logic signed [SW-1:0]   p_r, p_nxt, q_r, q_nxt;
  logic [3*COORD_WIDTH-1:0] coords2_r;
  arvt_pkg::ctrl_t        ctrl2_r;

  // stage 3: round, saturate, map to axes
  logic                   v3_r, rdy3;
  logic signed [SW-1:0]   p_rnd, q_rnd;
  logic signed [RW-1:0]   p_sh, q_sh;
  logic signed [COORD_WIDTH-1:0] p_sat, q_sat;
  logic signed [COORD_WIDTH-1:0] ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic signed [COORD_WIDTH-1:0] px, py, pz;

  assign cx = up_coords[0 +: COORD_WIDTH];
  assign cy = up_coords[COORD_WIDTH +: COORD_WIDTH];
  assign cz = up_coords[2*COORD_WIDTH +: COORD_WIDTH];

  // pick the two coordinates in the rotation plane
  always_comb begin
    case (up_ctrl.axis)
      arvt_pkg::AXIS_X: begin op_a = cy; op_b = cz; end
      arvt_pkg::AXIS_Y: begin op_a = cz; op_b = cx; end
      arvt_pkg::AXIS_Z: begin op_a = cx; op_b = cy; end
      default:          begin op_a = cx; op_b = cy; end
    endcase
  end

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= up_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && rdy1) begin
      pac_r     <= PW'(op_a * up_cos);
      pbs_r     <= PW'(op_b * up_sin);
      pas_r     <= PW'(op_a * up_sin);
      pbc_r     <= PW'(op_b * up_cos);
      coords1_r <= up_coords;
      ctrl1_r   <= up_ctrl;
    end
  end

  // a folded angle negates both cosine and sine, so negate the sums instead
  always_comb begin
    if (ctrl1_r.neg) begin
      p_nxt = SW'(pbs_r) - SW'(pac_r);
      q_nxt = -SW'(pas_r) - SW'(pbc_r);
    end else begin
      p_nxt = SW'(pac_r) - SW'(pbs_r);
      q_nxt = SW'(pas_r) + SW'(pbc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      p_r       <= p_nxt;
      q_r       <= q_nxt;
      coords2_r <= coords1_r;
      ctrl2_r   <= ctrl1_r;
    end
  end

  assign p_rnd = p_r + ROUND_HALF;
  assign q_rnd = q_r + ROUND_HALF;
  assign p_sh  = RW'(p_rnd >>> 30);
  assign q_sh  = RW'(q_rnd >>> 30);
  assign p_sat = (p_sh > SAT_HI) ? SAT_HI[COORD_WIDTH-1:0] :
                 (p_sh < SAT_LO) ? SAT_LO[COORD_WIDTH-1:0] : p_sh[COORD_WIDTH-1:0];
  assign q_sat = (q_sh > SAT_HI) ? SAT_HI[COORD_WIDTH-1:0] :
                 (q_sh < SAT_LO) ? SAT_LO[COORD_WIDTH-1:0] : q_sh[COORD_WIDTH-1:0];

  assign px = coords2_r[0 +: COORD_WIDTH];
  assign py = coords2_r[COORD_WIDTH +: COORD_WIDTH];
  assign pz = coords2_r[2*COORD_WIDTH +: COORD_WIDTH];

  // the coordinate along the axis passes through
  always_comb begin
    ox_nxt = px;
    oy_nxt = py;
    oz_nxt = pz;
    case (ctrl2_r.axis)
      arvt_pkg::AXIS_X: begin oy_nxt = p_sat; oz_nxt = q_sat; end
      arvt_pkg::AXIS_Y: begin oz_nxt = p_sat; ox_nxt = q_sat; end
      arvt_pkg::AXIS_Z: begin ox_nxt = p_sat; oy_nxt = q_sat; end
      default: begin end
    endcase
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      oz_r <= oz_nxt;
    end
  end

  assign dn_valid = v3_r;
  assign dn_x     = ox_r;
  assign dn_y     = oy_r;
  assign dn_z     = oz_r;

endmodule

// ===== rtl/axis_rotation_vertex_transform.sv =====
// Top level of the axis rotation vertex transform: spin angle counter,
// angle fold, a chain of CORDIC cells and the combine pipeline.
// Depends on arvt_pkg, arvt_cordic_cell and arvt_combine.
//
// Usage:
//   Input channel (in_valid/in_ready): one transaction is a tick
//   (in_command = 0) or a vertex (in_command = 1, in_x/in_y/in_z in Q2.14).
//   A tick advances the spin angle by a quarter degree; past 360 degrees the
//   angle returns to zero. Ticks produce no output transaction.
//   Output channel (out_valid/out_ready): one rotated vertex per vertex
//   transaction, in order, rounded and saturated to the coordinate range.
//   Config port: cfg_we/cfg_data selects the axis (0 x, 1 y, 2 z, 3 none).
//   Write it only while no vertex is in flight.
// Pipeline:
//   CORDIC_STAGES + 3 register stages (19 with default parameters): one per
//   CORDIC cell, then product, sum and round/saturate. Throughput is one
//   transaction per cycle while the output is not stalled. A vertex samples
//   the angle and axis at acceptance.
// Reset and stall:
//   rst_n (synchronous) clears the angle to zero, axis to x, and empties the
//   pipeline. When out_ready is low the pipeline holds its last result and
//   keeps accepting until every stage is full; bubbles collapse on the way.
module axis_rotation_vertex_transform #(
  parameter int COORD_WIDTH   = arvt_pkg::DEFAULT_COORD_WIDTH,
  parameter int CORDIC_STAGES = arvt_pkg::DEFAULT_CORDIC_STAGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_command,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_x,
  output logic signed [COORD_WIDTH-1:0] out_y,
  output logic signed [COORD_WIDTH-1:0] out_z,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_data
);

  localparam int XY_W = arvt_pkg::XY_W;
  localparam int Z_W  = arvt_pkg::Z_W;
  localparam int AW   = arvt_pkg::ANGLE_W;
  localparam logic signed [Z_W:0] QUARTER_TURN = 33'sh0_4000_0000;
  localparam logic signed [Z_W:0] HALF_TURN    = 33'sh0_8000_0000;

  // Angle state: quarter-degree count plus theta = round(q * 2^32 / 1440),
  // tracked as quotient (theta) and remainder so no divider is needed.
  logic [AW-1:0]   spin_r, spin_nxt;
  logic [AW-1:0]   rem_r, rem_nxt;
  logic [AW-1:0]   rem_sum;
  logic [Z_W-1:0]  theta_r, theta_nxt;
  arvt_pkg::axis_t axis_r;

  logic            tick_acc;

  // Folded start angle for the first cell
  logic signed [Z_W:0] th_ext, th_fold;
  logic                fold_neg;
  arvt_pkg::ctrl_t     ctrl0;

  // Cell chain links
  logic                            ch_valid  [CORDIC_STAGES+1];
  logic                            ch_ready  [CORDIC_STAGES+1];
  logic signed [XY_W-1:0]          ch_x      [CORDIC_STAGES+1];
  logic signed [XY_W-1:0]          ch_y      [CORDIC_STAGES+1];
  logic signed [Z_W-1:0]           ch_z      [CORDIC_STAGES+1];
  logic        [3*COORD_WIDTH-1:0] ch_coords [CORDIC_STAGES+1];
  arvt_pkg::ctrl_t                 ch_ctrl   [CORDIC_STAGES+1];

  assign in_ready = ch_ready[0];
  assign tick_acc = in_valid && in_ready && !in_command;

  // Advance the angle on a tick; wrap to zero once past a full turn
  always_comb begin
    spin_nxt  = spin_r;
    rem_nxt   = rem_r;
    theta_nxt = theta_r;
    rem_sum   = rem_r + arvt_pkg::REM_STEP;
    if (tick_acc) begin
      if (spin_r >= arvt_pkg::QUARTERS_FULL_TURN) begin
        spin_nxt  = '0;
        rem_nxt   = arvt_pkg::REM_INIT;
        theta_nxt = '0;
      end else begin
        spin_nxt = spin_r + AW'(1);
        if (rem_sum >= arvt_pkg::QUARTERS_FULL_TURN) begin
          rem_nxt   = rem_sum - arvt_pkg::QUARTERS_FULL_TURN;
          theta_nxt = theta_r + arvt_pkg::THETA_STEP + Z_W'(1);
        end else begin
          rem_nxt   = rem_sum;
          theta_nxt = theta_r + arvt_pkg::THETA_STEP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spin_r  <= '0;
      rem_r   <= arvt_pkg::REM_INIT;
      theta_r <= '0;
      axis_r  <= arvt_pkg::AXIS_X;
    end else begin
      spin_r  <= spin_nxt;
      rem_r   <= rem_nxt;
      theta_r <= theta_nxt;
      if (cfg_we) begin
        axis_r <= arvt_pkg::axis_t'(cfg_data);
      end
    end
  end

  // Fold theta into [-90, 90] degrees; the fold negates cosine and sine
  assign th_ext = {theta_r[Z_W-1], theta_r};
  always_comb begin
    fold_neg = 1'b0;
    th_fold  = th_ext;
    if (th_ext > QUARTER_TURN) begin
      th_fold  = th_ext - HALF_TURN;
      fold_neg = 1'b1;
    end else if (th_ext < -QUARTER_TURN) begin
      th_fold  = th_ext + HALF_TURN;
      fold_neg = 1'b1;
    end
  end

  assign ctrl0.axis = axis_r;
  assign ctrl0.neg  = fold_neg;

  // Vertices enter the first cell; ticks never do
  assign ch_valid[0]  = in_valid && in_command;
  assign ch_x[0]      = arvt_pkg::CORDIC_GAIN;
  assign ch_y[0]      = '0;
  assign ch_z[0]      = th_fold[Z_W-1:0];
  assign ch_coords[0] = {in_z, in_y, in_x};
  assign ch_ctrl[0]   = ctrl0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    arvt_cordic_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .STAGE       (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .up_valid  (ch_valid[i]),
      .up_ready  (ch_ready[i]),
      .up_x      (ch_x[i]),
      .up_y      (ch_y[i]),
      .up_z      (ch_z[i]),
      .up_coords (ch_coords[i]),
      .up_ctrl   (ch_ctrl[i]),
      .dn_valid  (ch_valid[i+1]),
      .dn_ready  (ch_ready[i+1]),
      .dn_x      (ch_x[i+1]),
      .dn_y      (ch_y[i+1]),
      .dn_z      (ch_z[i+1]),
      .dn_coords (ch_coords[i+1]),
      .dn_ctrl   (ch_ctrl[i+1])
    );
  end

  // Residual angle of the last cell is not needed past the chain
  arvt_combine #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_combine (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (ch_valid[CORDIC_STAGES]),
    .up_ready  (ch_ready[CORDIC_STAGES]),
    .up_cos    (ch_x[CORDIC_STAGES]),
    .up_sin    (ch_y[CORDIC_STAGES]),
    .up_coords (ch_coords[CORDIC_STAGES]),
    .up_ctrl   (ch_ctrl[CORDIC_STAGES]),
    .dn_valid  (out_valid),
    .dn_ready  (out_ready),
    .dn_x      (out_x),
    .dn_y      (out_y),
    .dn_z      (out_z)
  );

`ifndef SYNTHESIS
  a_spin_range: assert property (@(posedge clk) disable iff (!rst_n)
    spin_r <= arvt_pkg::QUARTERS_FULL_TURN)
    else $error("spin angle beyond a full turn");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < arvt_pkg::QUARTERS_FULL_TURN)
    else $error("theta remainder out of range");

  a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (spin_r == '0) |-> (theta_r == '0 && rem_r == arvt_pkg::REM_INIT))
    else $error("theta out of step with zero spin angle");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_acc && spin_r == arvt_pkg::QUARTERS_FULL_TURN) |=> (spin_r == '0))
    else $error("spin angle failed to wrap");

  a_tick_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_command) |-> !ch_valid[0])
    else $error("tick entered the rotation chain");
`endif

endmodule

// ===== dv/arvt_tb_pkg.sv =====
// Item kinds shared by the rotation monitor and the stimulus top.
// Depends on nothing; the DUT types come from arvt_pkg.
package arvt_tb_pkg;

  typedef enum logic {
    CMD_TICK   = 1'b0,
    CMD_VERTEX = 1'b1
  } cmd_t;

endpackage

// ===== dv/arvt_rotation_monitor.sv =====
// Passive monitor for the axis rotation vertex transform: tracks angle and axis,
// predicts each rotated vertex and compares it. Depends on arvt_pkg, arvt_tb_pkg.
module arvt_rotation_monitor (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_command,
  input  logic signed [15:0]   in_x,
  input  logic signed [15:0]   in_y,
  input  logic signed [15:0]   in_z,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [15:0]   out_x,
  input  logic signed [15:0]   out_y,
  input  logic signed [15:0]   out_z,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   compared
);

  localparam int CW     = arvt_pkg::DEFAULT_COORD_WIDTH;
  localparam int STAGES = arvt_pkg::DEFAULT_CORDIC_STAGES;

  localparam longint FULL_QUARTERS = 1440;
  localparam longint TURN_FULL     = longint'(1) << 32;
  localparam longint TURN_HALF     = longint'(1) << 31;
  localparam longint TURN_QUARTER  = longint'(1) << 30;
  localparam longint ROUND_HALF    = longint'(1) << 29;
  localparam longint SAT_HI        = (longint'(1) << (CW - 1)) - 1;
  localparam longint SAT_LO        = -SAT_HI - 1;

  // arctan(2^-i) in binary turns, 2^32 per revolution
  localparam longint ATAN_TURNS [32] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
    32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
    32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
  };

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vertex_t;

  logic [10:0]       spin_q;
  arvt_pkg::axis_t   axis_q;
  vertex_t           rotated_fifo[$];

  // Cosine and sine in Q1.30 for an angle given in quarter degrees.
  function automatic void cordic_sincos(input logic [10:0] q, output longint c,
                                        output longint s);
    longint zz, xx, yy, nx;
    bit     flip;
    zz = ((longint'(q) << 32) + FULL_QUARTERS / 2) / FULL_QUARTERS;
    zz = zz & (TURN_FULL - 1);
    xx = arvt_pkg::CORDIC_GAIN;
    yy = 0;
    flip = 1'b0;
    if (zz >= TURN_HALF) zz = zz - TURN_FULL;
    // fold into [-90, 90] degrees; the half turn negates both outputs
    if (zz > TURN_QUARTER) begin
      zz = zz - TURN_HALF;
      flip = 1'b1;
    end else if (zz < -TURN_QUARTER) begin
      zz = zz + TURN_HALF;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES && i < 32; i++) begin
      if (zz >= 0) begin
        nx = xx - (yy >>> i);
        yy = yy + (xx >>> i);
        zz = zz - ATAN_TURNS[i];
      end else begin
        nx = xx + (yy >>> i);
        yy = yy - (xx >>> i);
        zz = zz + ATAN_TURNS[i];
      end
      xx = nx;
    end
    c = flip ? -xx : xx;
    s = flip ? -yy : yy;
  endfunction

  function automatic logic signed [CW-1:0] mix_round_sat(input longint a, input longint ca,
                                                         input longint b, input longint cb);
    longint r;
    r = (a * ca + b * cb + ROUND_HALF) >>> 30;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r[CW-1:0];
  endfunction

  function automatic vertex_t rotate_vertex(input arvt_pkg::axis_t ax, input logic [10:0] q,
                                            input vertex_t v);
    longint  c, s;
    vertex_t r;
    r = v;
    cordic_sincos(q, c, s);
    case (ax)
      arvt_pkg::AXIS_X: begin
        r.y = mix_round_sat(v.y, c, v.z, -s);
        r.z = mix_round_sat(v.y, s, v.z, c);
      end
      arvt_pkg::AXIS_Y: begin
        r.x = mix_round_sat(v.z, s, v.x, c);
        r.z = mix_round_sat(v.z, c, v.x, -s);
      end
      arvt_pkg::AXIS_Z: begin
        r.x = mix_round_sat(v.x, c, v.y, -s);
        r.y = mix_round_sat(v.x, s, v.y, c);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    vertex_t inv, want;
    if (!rst_n) begin
      spin_q = '0;
      axis_q = arvt_pkg::AXIS_X;
      rotated_fifo.delete();
    end else begin
      if (cfg_we) axis_q = arvt_pkg::axis_t'(cfg_data);
      if (in_valid && in_ready) begin
        if (in_command == arvt_tb_pkg::CMD_VERTEX) begin
          inv.x = in_x;
          inv.y = in_y;
          inv.z = in_z;
          rotated_fifo.push_back(rotate_vertex(axis_q, spin_q, inv));
        end else begin
          spin_q = (spin_q == 11'(FULL_QUARTERS)) ? '0 : spin_q + 11'd1;
        end
      end
      if (out_valid && out_ready) begin
        if (rotated_fifo.size() == 0) begin
          $error("unexpected rotated vertex (%0d, %0d, %0d)", out_x, out_y, out_z);
          fail_count++;
        end else begin
          want = rotated_fifo.pop_front();
          compared++;
          if (out_x !== want.x) begin
            $error("out_x: expected %0d, got %0d", want.x, out_x);
            fail_count++;
          end
          if (out_y !== want.y) begin
            $error("out_y: expected %0d, got %0d", want.y, out_y);
            fail_count++;
          end
          if (out_z !== want.z) begin
            $error("out_z: expected %0d, got %0d", want.z, out_z);
            fail_count++;
          end
        end
      end
    end
    pending = rotated_fifo.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Stimulus top for the axis rotation vertex transform: clock, reset, axis
// phases, directed and random traffic, output stalls and the final verdict.
// Depends on arvt_pkg, arvt_tb_pkg, arvt_rotation_monitor and the DUT.
module tb_top;

  localparam int CW             = arvt_pkg::DEFAULT_COORD_WIDTH;
  // register stages from acceptance to the result, plus some slack
  localparam int LATENCY        = arvt_pkg::DEFAULT_CORDIC_STAGES + 3;
  localparam int DRAIN_CYCLES   = LATENCY + 6;
  localparam int PHASES         = 6;
  localparam int RANDOM_ITEMS   = 1560;
  localparam int FLOOD_VERTICES = 48;
  localparam int HOLD_CYCLES    = 90;
  localparam int TICK_PERCENT   = 90;
  localparam int WRAP_TICKS     = 1441;
  localparam int TIMEOUT_UNITS  = 2_000_000;

  localparam logic signed [CW-1:0] C_MAX = 16'sh7FFF;
  localparam logic signed [CW-1:0] C_MIN = 16'sh8000;
  localparam logic signed [CW-1:0] C_ONE = 16'sh4000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_valid   = 1'b0;
  logic                 in_ready;
  logic                 in_command = 1'b0;
  logic signed [CW-1:0] in_x       = '0;
  logic signed [CW-1:0] in_y       = '0;
  logic signed [CW-1:0] in_z       = '0;
  logic                 out_valid;
  logic                 out_ready  = 1'b0;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic                 cfg_we     = 1'b0;
  logic [1:0]           cfg_data   = '0;

  int fail_count;
  int pending;
  int compared;
  int ticks_sent;
  int vertices_sent;
  int axis_writes;

  // handshake between the stimulus and the receiver for the long stall
  bit hold_req;
  bit hold_started;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  axis_rotation_vertex_transform dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data)
  );

  arvt_rotation_monitor rot_mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_command (in_command),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_x      (out_x),
    .out_y      (out_y),
    .out_z      (out_z),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .compared   (compared)
  );

  // Offer one transaction and hold it until accepted. Call at a rising edge;
  // returns at the edge that took it. in_ready is sampled at the falling edge,
  // where it already shows what the next rising edge will see.
  task automatic send_item(input arvt_tb_pkg::cmd_t cmd, input logic signed [CW-1:0] x,
                           input logic signed [CW-1:0] y, input logic signed [CW-1:0] z);
    logic took;
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_x       <= x;
    in_y       <= y;
    in_z       <= z;
    took = 1'b0;
    while (!took) begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end
    if (cmd == arvt_tb_pkg::CMD_VERTEX) vertices_sent++;
    else ticks_sent++;
  endtask

  // Drop valid for a number of cycles; zero keeps the stream back to back.
  task automatic idle_for(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Mix full-range values with the extremes, values within unit length and values
  // near zero so that rotations both stay in range and saturate.
  function automatic logic signed [CW-1:0] rand_coord();
    logic signed [CW-1:0] v;
    case ($urandom_range(0, 6))
      0, 1, 2: v = CW'($urandom);
      3:       v = C_MAX;
      4:       v = C_MIN;
      5:       v = CW'($signed($urandom_range(0, 32768)) - 16384);
      default: v = CW'($signed($urandom_range(0, 15)) - 8);
    endcase
    return v;
  endfunction

  task automatic send_random_item();
    if ($urandom_range(0, 99) < TICK_PERCENT)
      send_item(arvt_tb_pkg::CMD_TICK, CW'($urandom), CW'($urandom), CW'($urandom));
    else
      send_item(arvt_tb_pkg::CMD_VERTEX, rand_coord(), rand_coord(), rand_coord());
  endtask

  // Wait for every rotated vertex to come back, wait out the pipeline depth,
  // then write the axis register in one cycle.
  task automatic drain_and_set_axis(input arvt_pkg::axis_t ax);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= ax;
    @(posedge clk);
    cfg_we   <= 1'b0;
    axis_writes++;
  endtask

  // Receiver: random ready patterns, plus one long hold-off on request so the
  // pipeline fills and back-pressures the input.
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_started) begin
        out_ready    <= 1'b0;
        hold_started = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
          end
          1: begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
          default: begin
            n = $urandom_range(1, 30);
            repeat (n) begin
              out_ready <= 1'($urandom_range(0, 1));
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  // Stop a hung run.
  initial begin
    #(TIMEOUT_UNITS);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    arvt_pkg::axis_t dir_axes[4];
    arvt_pkg::axis_t phase_axes[PHASES];
    int phase_items;
    int burst;
    bit more;

    dir_axes   = '{arvt_pkg::AXIS_X, arvt_pkg::AXIS_Y, arvt_pkg::AXIS_Z, arvt_pkg::AXIS_NONE};
    phase_axes = '{arvt_pkg::AXIS_X, arvt_pkg::AXIS_Z, arvt_pkg::AXIS_Y,
                   arvt_pkg::AXIS_NONE, arvt_pkg::AXIS_Z, arvt_pkg::AXIS_X};

    // Hold reset once at the start.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme points on every axis setting, including the
    // pass-through setting, with a tick between settings so small nonzero
    // angles are hit too.
    foreach (dir_axes[i]) begin
      drain_and_set_axis(dir_axes[i]);
      send_item(arvt_tb_pkg::CMD_VERTEX, C_MAX, C_MAX, C_MAX);
      send_item(arvt_tb_pkg::CMD_VERTEX, C_MIN, C_MIN, C_MIN);
      send_item(arvt_tb_pkg::CMD_VERTEX, C_MAX, C_MIN, 16'sd0);
      send_item(arvt_tb_pkg::CMD_VERTEX, C_MIN, C_MAX, -16'sd1);
      send_item(arvt_tb_pkg::CMD_VERTEX, C_ONE, -C_ONE, 16'sd0);
      send_item(arvt_tb_pkg::CMD_TICK, C_MAX, C_MIN, C_MAX);
    end

    // Random phases, one axis setting each. Ticks dominate so the angle
    // sweeps all four quadrants and wraps past 360 degrees at least once.
    foreach (phase_axes[p]) begin
      drain_and_set_axis(phase_axes[p]);

      if (p == 0) begin
        // Flood the block with vertices while the receiver holds off.
        hold_req = 1'b1;
        while (!hold_started) @(posedge clk);
        repeat (FLOOD_VERTICES)
          send_item(arvt_tb_pkg::CMD_VERTEX, rand_coord(), rand_coord(), rand_coord());
      end

      phase_items = 0;
      more = 1'b1;
      while (more) begin
        burst = $urandom_range(1, 24);
        repeat (burst) begin
          send_random_item();
          phase_items++;
        end
        if ($urandom_range(0, 2) != 0) idle_for($urandom_range(1, 6));
        more = phase_items < RANDOM_ITEMS / PHASES;
        // keep the last phase going until the angle has wrapped
        if (p == PHASES - 1 && (ticks_sent <= WRAP_TICKS + 8 || vertices_sent < 60))
          more = 1'b1;
      end
    end

    // Drain: every rotated vertex back, then allow for the pipeline depth.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d ticks (angle wrapped %0d times) and %0d vertices",
             ticks_sent, ticks_sent / WRAP_TICKS, vertices_sent);
    $display("over %0d axis writes; compared %0d rotated vertices, %0d errors.",
             axis_writes, compared, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
